[rtl/core/bfs_pkg.sv]
// Shared types and codes for the breadth-first shortest path core.
package bfs_pkg;

  localparam int NODE_W    = 4;   // width of a node field on the ports
  localparam int FUNC_W    = 2;
  localparam int OUT_LIMIT = 16;  // most path nodes reported per search
  localparam int STEP_W    = 4;   // counts 0 .. OUT_LIMIT-1

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP,
    ST_POP_WAIT,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_CHECK,
    ST_WALK,
    ST_WALK_WAIT,
    ST_MISS
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [NODE_W-1:0] vertex;
    logic [NODE_W-1:0] neighbor;
    logic [NODE_W-1:0] target;
  } bfs_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] path_vertex;
    logic              found;
    logic              last;
  } bfs_out_t;

endpackage

[rtl/core/bfs_stream_if.sv]
// Valid/ready stream channel carrying one word of type T.
interface bfs_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[rtl/core/bfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bfs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/core/bfs_shortest_path_core.sv]
// Top level: adjacency store, BFS sequencer and path walk.
//
//  channel | dir | payload                            | accept
//  req     | in  | func, vertex, neighbor, target     | req.valid & req.ready
//  rsp     | out | path_vertex, found, last           | rsp.valid & rsp.ready
//
// Append, clear and unused codes leave the core idle, so req.ready stays high.
// Search: a start step, then for each dequeued node a queue read and a scan of its list,
// each entry read from the neighbor RAM, then the empty-queue pop and target check,
// then a walk back through the discoverer RAM, one word per path node; the reads of the
// neighbor, queue and discoverer RAMs are registered. req.ready is low for the whole search.
// Reset clears list counts, visited marks and the output valid flag; no RAM sweep.
// A stalled rsp holds the walk until the word is taken.
module bfs_shortest_path_core #(
  parameter int NODES      = 16,
  parameter int MAX_DEGREE = 16
) (
  input logic clk,
  input logic rst,
  bfs_stream_if.sink   req,
  bfs_stream_if.source rsp
);
  import bfs_pkg::*;

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;  // node index
  localparam int XW = NW + NODE_W;                      // room to compare port fields
  localparam int HW = $clog2(NODES + 1);                // queue pointers
  localparam int CW = $clog2(MAX_DEGREE + 1);           // list counts
  localparam int AW = $clog2(NODES * MAX_DEGREE);       // neighbor store address

  state_t state, state_next;
  logic [CW-1:0] deg [NODES];
  logic [CW-1:0] deg_next [NODES];
  logic [NODES-1:0] seen, seen_next;
  logic [HW-1:0] head, head_next, tail, tail_next;
  logic [NW-1:0] u, u_next, src, src_next, tgt, tgt_next, cur, cur_next;
  logic [CW-1:0] i, i_next;
  logic [STEP_W-1:0] k, k_next;
  logic out_valid, out_valid_next;
  bfs_out_t out_data, out_data_next;

  // RAM ports
  logic              ns_we, ns_re;
  logic [AW-1:0]     ns_waddr, ns_raddr;
  logic [NODE_W-1:0] ns_wdata, ns_rdata;
  logic              q_we, q_re;
  logic [NW-1:0]     q_waddr, q_raddr, q_wdata, q_rdata;
  logic              d_we, d_re;
  logic [NW-1:0]     d_waddr, d_raddr, d_wdata, d_rdata;

  logic [XW-1:0] v_ext, nb_ext, t_ext, w_ext, cur_ext;
  logic v_ok, nb_ok, t_ok, w_ok, out_free, at_end;

  assign v_ext   = XW'(req.data.vertex);
  assign nb_ext  = XW'(req.data.neighbor);
  assign t_ext   = XW'(req.data.target);
  assign w_ext   = XW'(ns_rdata);
  assign cur_ext = XW'(cur);
  assign v_ok    = v_ext < XW'(NODES);
  assign nb_ok   = nb_ext < XW'(NODES);
  assign t_ok    = t_ext < XW'(NODES);
  assign w_ok    = w_ext < XW'(NODES);

  assign out_free  = !out_valid || rsp.ready;
  assign at_end    = (cur == src) || (k == STEP_W'(OUT_LIMIT - 1));
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  bfs_ram #(.WIDTH(NODE_W), .DEPTH(NODES * MAX_DEGREE)) u_nbr_ram (
    .clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
    .re(ns_re), .raddr(ns_raddr), .rdata(ns_rdata)
  );

  bfs_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  bfs_ram #(.WIDTH(NW), .DEPTH(NODES)) u_disc_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
  );

  always_comb begin
    state_next     = state;
    deg_next       = deg;
    seen_next      = seen;
    head_next      = head;
    tail_next      = tail;
    u_next         = u;
    src_next       = src;
    tgt_next       = tgt;
    cur_next       = cur;
    i_next         = i;
    k_next         = k;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    ns_we = 1'b0; ns_waddr = '0; ns_wdata = '0; ns_re = 1'b0; ns_raddr = '0;
    q_we  = 1'b0; q_waddr  = '0; q_wdata  = '0; q_re  = 1'b0; q_raddr  = '0;
    d_we  = 1'b0; d_waddr  = '0; d_wdata  = '0; d_re  = 1'b0; d_raddr  = '0;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.data.func)
            FUNC_APPEND: begin
              if (v_ok && nb_ok && deg[v_ext[NW-1:0]] < CW'(MAX_DEGREE)) begin
                ns_we    = 1'b1;
                ns_waddr = AW'(v_ext[NW-1:0]) * AW'(MAX_DEGREE)
                         + AW'(deg[v_ext[NW-1:0]]);
                ns_wdata = req.data.neighbor;
                deg_next[v_ext[NW-1:0]] = deg[v_ext[NW-1:0]] + CW'(1);
              end
            end
            FUNC_CLEAR: begin
              deg_next = '{default: '0};
            end
            FUNC_SEARCH: begin
              src_next = v_ext[NW-1:0];
              tgt_next = t_ext[NW-1:0];
              if (v_ok && t_ok) begin
                seen_next = '0;
                seen_next[v_ext[NW-1:0]] = 1'b1;
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = v_ext[NW-1:0];
                d_we    = 1'b1;
                d_waddr = v_ext[NW-1:0];
                d_wdata = v_ext[NW-1:0];
                head_next  = '0;
                tail_next  = HW'(1);
                state_next = ST_POP;
              end else begin
                state_next = ST_MISS;
              end
            end
            default: ;
          endcase
        end
      end

      ST_POP: begin
        if (head < tail) begin
          q_re       = 1'b1;
          q_raddr    = head[NW-1:0];
          head_next  = head + HW'(1);
          state_next = ST_POP_WAIT;
        end else begin
          state_next = ST_CHECK;
        end
      end

      ST_POP_WAIT: begin
        u_next     = q_rdata;
        i_next     = '0;
        state_next = ST_SCAN;
      end

      ST_SCAN: begin
        if (i < deg[u]) begin
          ns_re      = 1'b1;
          ns_raddr   = AW'(u) * AW'(MAX_DEGREE) + AW'(i);
          i_next     = i + CW'(1);
          state_next = ST_SCAN_WAIT;
        end else begin
          state_next = ST_POP;
        end
      end

      ST_SCAN_WAIT: begin
        // first discoverer wins; queue never grows past NODES
        if (w_ok && !seen[w_ext[NW-1:0]] && tail < HW'(NODES)) begin
          seen_next[w_ext[NW-1:0]] = 1'b1;
          d_we      = 1'b1;
          d_waddr   = w_ext[NW-1:0];
          d_wdata   = u;
          q_we      = 1'b1;
          q_waddr   = tail[NW-1:0];
          q_wdata   = w_ext[NW-1:0];
          tail_next = tail + HW'(1);
        end
        state_next = ST_SCAN;
      end

      ST_CHECK: begin
        if (seen[tgt]) begin
          cur_next   = tgt;
          k_next     = '0;
          state_next = ST_WALK;
        end else begin
          state_next = ST_MISS;
        end
      end

      ST_MISS: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = '{path_vertex: '0, found: 1'b0, last: 1'b1};
          state_next     = ST_IDLE;
        end
      end

      ST_WALK: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = '{path_vertex: cur_ext[NODE_W-1:0], found: 1'b1, last: at_end};
          if (at_end) begin
            state_next = ST_IDLE;
          end else begin
            d_re       = 1'b1;
            d_raddr    = cur;
            k_next     = k + STEP_W'(1);
            state_next = ST_WALK_WAIT;
          end
        end
      end

      ST_WALK_WAIT: begin
        cur_next   = d_rdata;
        state_next = ST_WALK;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      deg       <= '{default: '0};
      seen      <= '0;
      head      <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      deg       <= deg_next;
      seen      <= seen_next;
      head      <= head_next;
      tail      <= tail_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    u        <= u_next;
    src      <= src_next;
    tgt      <= tgt_next;
    cur      <= cur_next;
    i        <= i_next;
    k        <= k_next;
    out_data <= out_data_next;
  end

  // queue pointers stay ordered and bounded
  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    (head <= tail) && (tail <= HW'(NODES)))
    else $error("queue pointers out of order");

  // a miss is always a single final word with node zero
  a_miss_word: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.data.found) |-> (rsp.data.last && rsp.data.path_vertex == '0))
    else $error("malformed miss word");

  // neighbor data is consumed only the cycle after its read
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_WAIT) |-> ($past(state) == ST_SCAN))
    else $error("scan data used without a read");

  // a stalled result word is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(out_data)))
    else $error("result word lost while stalled");
endmodule
